FILE: hw/rtl/fgp_pkg.sv
package fgp_pkg;

   // configuration port
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 12;
   localparam int unsigned GAIN_W      = 12;
   localparam int unsigned LIMIT_W     = 7;

   localparam logic [CSR_INDEX_W-1:0] REG_P_GAIN_LOW      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_P_GAIN_HIGH     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_D_GAIN_BASE     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_P_GAIN_LOW_ALT  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_P_GAIN_HIGH_ALT = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_D_GAIN_BASE_ALT = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_P_TERM_LIMIT    = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_DRIVE_LIMIT     = 3'd7;

   localparam logic [GAIN_W-1:0]  RST_P_GAIN_LOW      = 12'd230;
   localparam logic [GAIN_W-1:0]  RST_P_GAIN_HIGH     = 12'd320;
   localparam logic [GAIN_W-1:0]  RST_D_GAIN_BASE     = 12'd14;
   localparam logic [GAIN_W-1:0]  RST_P_GAIN_LOW_ALT  = 12'd155;
   localparam logic [GAIN_W-1:0]  RST_P_GAIN_HIGH_ALT = 12'd155;
   localparam logic [GAIN_W-1:0]  RST_D_GAIN_BASE_ALT = 12'd0;
   localparam logic [LIMIT_W-1:0] RST_P_TERM_LIMIT    = 7'd100;
   localparam logic [LIMIT_W-1:0] RST_DRIVE_LIMIT     = 7'd100;

   // membership breakpoints
   localparam logic [11:0] ERR_BP1  = 12'd50;
   localparam logic [11:0] ERR_BP2  = 12'd100;
   localparam logic [11:0] ERR_BP3  = 12'd150;
   localparam logic [15:0] RATE_BP0 = 16'd110;
   localparam logic [15:0] RATE_BP1 = 16'd150;
   localparam logic [15:0] RATE_BP2 = 16'd250;
   localparam logic [15:0] RATE_BP3 = 16'd350;

   // weights on a common denominator: error over 50, rate over 200
   localparam logic [5:0]  ERR_HALF_W       = 6'd25;
   localparam logic [7:0]  RATE_HALF_W      = 8'd100;
   localparam logic [15:0] RATE_BAND0_SCALE = 16'd5;
   localparam logic [15:0] RATE_BAND_SCALE  = 16'd2;

   // 7x7 rule table, row = error level, column = rate level, both 0..6
   localparam logic [2:0] RULE_TABLE [49] = '{
      3'd4, 3'd3, 3'd1, 3'd0, 3'd0, 3'd0, 3'd0,
      3'd4, 3'd4, 3'd2, 3'd0, 3'd0, 3'd0, 3'd0,
      3'd4, 3'd4, 3'd2, 3'd0, 3'd0, 3'd0, 3'd0,
      3'd4, 3'd4, 3'd3, 3'd0, 3'd3, 3'd4, 3'd4,
      3'd0, 3'd0, 3'd0, 3'd0, 3'd2, 3'd4, 3'd4,
      3'd0, 3'd0, 3'd0, 3'd0, 3'd2, 3'd4, 3'd4,
      3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd3, 3'd4
   };

   // divide by 1000 through reciprocals: p side floor(x/125), x < 2^22
   localparam int unsigned P_SHIFT = 29;
   localparam logic [22:0] P_RECIP = 23'd4294968;
   // d side floor(x/125) with x = md/8 < 2^23
   localparam int unsigned D_SHIFT = 30;
   localparam logic [23:0] D_RECIP = 24'd8589935;

   // fuzzy sum: num over 10000, scaled by 256 -> num*16/625
   localparam int unsigned NUM_W    = 16;
   localparam int unsigned FZ_SHIFT = 25;
   localparam longint unsigned FZ_DEN = 625;

   localparam logic [19:0] DGAIN_MAX = 20'hFFFFF;

   typedef struct packed {
      logic signed [11:0] target_pos;
      logic signed [11:0] measured_pos;
      logic signed [15:0] yaw_rate;
      logic               alt_mode;
      logic               high_track;
   } req_type;

   typedef struct packed {
      logic signed [15:0] drive;
      logic [19:0]        d_gain_used;
   } rsp_type;

   typedef struct packed {
      logic [GAIN_W-1:0] p_gain_low;
      logic [GAIN_W-1:0] p_gain_high;
      logic [GAIN_W-1:0] d_gain_base;
      logic [GAIN_W-1:0] p_gain_low_alt;
      logic [GAIN_W-1:0] p_gain_high_alt;
      logic [GAIN_W-1:0] d_gain_base_alt;
   } gain_set_type;

   typedef struct packed {
      logic [LIMIT_W-1:0] p_term_limit;
      logic [LIMIT_W-1:0] drive_limit;
   } limit_set_type;

   // classified item as it sits in the queue
   typedef struct packed {
      logic              err_neg;
      logic [11:0]       err_mag;
      logic              rate_neg;
      logic [15:0]       rate_mag;
      logic [GAIN_W-1:0] p_gain;
      logic [GAIN_W-1:0] d_gain_base;
      logic [2:0]        rule_ll;
      logic [2:0]        rule_lh;
      logic [2:0]        rule_hl;
      logic [2:0]        rule_hh;
      logic [5:0]        err_w_lo;
      logic [5:0]        err_w_hi;
      logic [7:0]        rate_w_lo;
      logic [7:0]        rate_w_hi;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_head_type;

endpackage

FILE: hw/rtl/fgp_front.sv
module fgp_front
   import fgp_pkg::*;
(
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_type      req_data,
   input  gain_set_type gains,
   input  logic         queue_full,
   output logic         push,
   output item_type     item
);

   localparam logic [2:0] LVL_NEG_BIG = 3'd0;
   localparam logic [2:0] LVL_ZERO    = 3'd3;
   localparam logic [2:0] LVL_POS_BIG = 3'd6;

   function automatic logic [2:0] rule_at(input logic [2:0] e_lvl, input logic [2:0] r_lvl);
      logic [5:0] idx;
      idx = 6'({3'd0, e_lvl} * 6'd7) + {3'd0, r_lvl};
      return RULE_TABLE[idx];
   endfunction

   logic signed [12:0] err;
   logic [1:0]  e_k;
   logic [11:0] e_lower;
   logic [11:0] e_upper;
   logic [5:0]  e_dlo;
   logic [5:0]  e_dhi;
   logic [2:0]  e_lo;
   logic [2:0]  e_hi;
   logic [1:0]  r_k;
   logic [15:0] r_lower;
   logic [15:0] r_upper;
   logic [15:0] r_scale;
   logic [7:0]  r_dlo;
   logic [7:0]  r_dhi;
   logic [2:0]  r_lo;
   logic [2:0]  r_hi;

   assign busy = reset | queue_full;
   assign push = start & ~busy;

   always_comb begin
      err = {req_data.target_pos[11], req_data.target_pos}
          - {req_data.measured_pos[11], req_data.measured_pos};
      item.err_neg  = err[12];
      item.err_mag  = err[12] ? 12'(-err) : err[11:0];
      item.rate_neg = req_data.yaw_rate[15];
      item.rate_mag = req_data.yaw_rate[15] ? 16'(~req_data.yaw_rate) + 16'd1
                                            : req_data.yaw_rate;

      if (req_data.alt_mode) begin
         item.p_gain      = req_data.high_track ? gains.p_gain_high_alt : gains.p_gain_low_alt;
         item.d_gain_base = gains.d_gain_base_alt;
      end else begin
         item.p_gain      = req_data.high_track ? gains.p_gain_high : gains.p_gain_low;
         item.d_gain_base = gains.d_gain_base;
      end

      // error membership
      priority if (item.err_mag > ERR_BP2) begin
         e_k = 2'd2; e_lower = ERR_BP2; e_upper = ERR_BP3;
      end else if (item.err_mag > ERR_BP1) begin
         e_k = 2'd1; e_lower = ERR_BP1; e_upper = ERR_BP2;
      end else begin
         e_k = 2'd0; e_lower = 12'd0; e_upper = ERR_BP1;
      end
      e_dhi = 6'(item.err_mag - e_lower);
      e_dlo = 6'(e_upper - item.err_mag);
      priority if (item.err_mag == 12'd0) begin
         e_lo = LVL_ZERO; e_hi = LVL_ZERO;
         item.err_w_lo = ERR_HALF_W; item.err_w_hi = ERR_HALF_W;
      end else if (item.err_mag > ERR_BP3) begin
         e_lo = item.err_neg ? LVL_NEG_BIG : LVL_POS_BIG;
         e_hi = e_lo;
         item.err_w_lo = ERR_HALF_W; item.err_w_hi = ERR_HALF_W;
      end else if (!item.err_neg) begin
         e_lo = LVL_ZERO + {1'b0, e_k};
         e_hi = LVL_ZERO + 3'd1 + {1'b0, e_k};
         item.err_w_lo = e_dlo; item.err_w_hi = e_dhi;
      end else begin
         e_lo = LVL_ZERO - 3'd1 - {1'b0, e_k};
         e_hi = LVL_ZERO - {1'b0, e_k};
         item.err_w_lo = e_dhi; item.err_w_hi = e_dlo;
      end

      // rate membership, band weights brought to a denominator of 200
      priority if (item.rate_mag > RATE_BP2) begin
         r_k = 2'd2; r_lower = RATE_BP2; r_upper = RATE_BP3; r_scale = RATE_BAND_SCALE;
      end else if (item.rate_mag > RATE_BP1) begin
         r_k = 2'd1; r_lower = RATE_BP1; r_upper = RATE_BP2; r_scale = RATE_BAND_SCALE;
      end else begin
         r_k = 2'd0; r_lower = RATE_BP0; r_upper = RATE_BP1; r_scale = RATE_BAND0_SCALE;
      end
      r_dhi = 8'((item.rate_mag - r_lower) * r_scale);
      r_dlo = 8'((r_upper - item.rate_mag) * r_scale);
      priority if (item.rate_mag <= RATE_BP0) begin
         r_lo = LVL_ZERO; r_hi = LVL_ZERO;
         item.rate_w_lo = RATE_HALF_W; item.rate_w_hi = RATE_HALF_W;
      end else if (item.rate_mag > RATE_BP3) begin
         r_lo = item.rate_neg ? LVL_NEG_BIG : LVL_POS_BIG;
         r_hi = r_lo;
         item.rate_w_lo = RATE_HALF_W; item.rate_w_hi = RATE_HALF_W;
      end else if (!item.rate_neg) begin
         r_lo = LVL_ZERO + {1'b0, r_k};
         r_hi = LVL_ZERO + 3'd1 + {1'b0, r_k};
         item.rate_w_lo = r_dlo; item.rate_w_hi = r_dhi;
      end else begin
         r_lo = LVL_ZERO - 3'd1 - {1'b0, r_k};
         r_hi = LVL_ZERO - {1'b0, r_k};
         item.rate_w_lo = r_dhi; item.rate_w_hi = r_dlo;
      end

      item.rule_ll = rule_at(e_lo, r_lo);
      item.rule_lh = rule_at(e_lo, r_hi);
      item.rule_hl = rule_at(e_hi, r_lo);
      item.rule_hh = rule_at(e_hi, r_hi);
   end

endmodule

FILE: hw/rtl/fgp_queue.sv
module fgp_queue
   import fgp_pkg::*;
#(
   parameter int unsigned DEPTH = 4
)
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  item_type       push_item,
   output logic           full,
   output queue_head_type head
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
   localparam logic [PTR_W-1:0] PTR_ONE  = PTR_W'(1);
   localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

   item_type         entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             pop;

   // the back end never stalls, so the head leaves in every cycle it is valid
   assign pop        = (count_ff != '0);
   assign full       = (count_ff == FULL_CNT);
   assign head.valid = pop;
   assign head.item  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_ONE;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_ONE;
      end
      unique case ({push, pop})
         2'b10:   count_in = count_ff + CNT_ONE;
         2'b01:   count_in = count_ff - CNT_ONE;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

FILE: hw/rtl/fgp_back.sv
module fgp_back
   import fgp_pkg::*;
#(
   parameter int unsigned FUZZY_SCALE = 2
)
(
   input  logic           clock,
   input  logic           reset,
   input  queue_head_type head,
   input  limit_set_type  limits,
   output logic           rsp_strobe,
   output rsp_type        rsp_data
);

   // fuzzy increment = floor(num * FUZZY_SCALE * 16 / 625), by reciprocal
   localparam longint unsigned FZ_NUM  = longint'(FUZZY_SCALE) * 16;
   localparam longint unsigned FZ_MULT =
      (FZ_NUM * (64'd1 << FZ_SHIFT) + FZ_DEN - 1) / FZ_DEN;
   localparam int unsigned FZ_MULT_W = (FZ_MULT == 0) ? 1 : $clog2(FZ_MULT + 1);
   localparam int unsigned FZ_W      = (FUZZY_SCALE == 0) ? 1
                                       : $clog2(FUZZY_SCALE * 1024 + 1);
   localparam int unsigned FZ_PROD_W =
      (NUM_W + FZ_MULT_W > FZ_W + FZ_SHIFT) ? NUM_W + FZ_MULT_W : FZ_W + FZ_SHIFT;

   // stage 1: rule products and |err| * p gain
   logic              s1_valid_ff;
   logic [15:0]       s1_prod_ff [4];
   logic [23:0]       s1_pm_ff;
   logic              s1_err_neg_ff;
   logic              s1_rate_neg_ff;
   logic [15:0]       s1_rate_mag_ff;
   logic [GAIN_W-1:0] s1_dbase_ff;
   // stage 2: fuzzy numerator, p quotient
   logic              s2_valid_ff;
   logic [NUM_W-1:0]  s2_num_ff;
   logic [NUM_W-1:0]  s2_num_in;
   logic [15:0]       s2_pq_ff;
   logic [16:0]       s2_pm_sat;
   logic [44:0]       s2_p_prod;
   logic              s2_err_neg_ff;
   logic              s2_rate_neg_ff;
   logic [15:0]       s2_rate_mag_ff;
   logic [GAIN_W-1:0] s2_dbase_ff;
   // stage 3: fuzzy increment, clamped p term
   logic                 s3_valid_ff;
   logic [FZ_PROD_W-1:0] s3_fz_prod;
   logic [FZ_W-1:0]      s3_fz_ff;
   logic [15:0]          s3_plim;
   logic [15:0]          s3_pmag;
   logic signed [15:0]   s3_pterm_ff;
   logic signed [15:0]   s3_pterm_in;
   logic                 s3_rate_neg_ff;
   logic [15:0]          s3_rate_mag_ff;
   logic [GAIN_W-1:0]    s3_dbase_ff;
   // stage 4: effective d gain
   logic               s4_valid_ff;
   logic [20:0]        s4_dgain_sum;
   logic [19:0]        s4_dgain_ff;
   logic [19:0]        s4_dgain_in;
   logic signed [15:0] s4_pterm_ff;
   logic               s4_rate_neg_ff;
   logic [15:0]        s4_rate_mag_ff;
   // stage 5: d gain * |rate|
   logic               s5_valid_ff;
   logic [35:0]        s5_md_ff;
   logic [19:0]        s5_dgain_ff;
   logic signed [15:0] s5_pterm_ff;
   logic               s5_rate_neg_ff;
   // stage 6: d quotient
   logic               s6_valid_ff;
   logic [25:0]        s6_md_sat;
   logic [46:0]        s6_d_prod;
   logic [16:0]        s6_dq_ff;
   logic [19:0]        s6_dgain_ff;
   logic signed [15:0] s6_pterm_ff;
   logic               s6_rate_neg_ff;
   // output stage
   logic signed [17:0] out_dterm;
   logic signed [17:0] out_sum;
   logic signed [17:0] out_lim;
   logic signed [17:0] out_clamped;
   logic               rsp_strobe_ff;
   rsp_type            rsp_data_ff;
   rsp_type            rsp_data_in;

   always_comb begin
      s2_num_in = s1_prod_ff[0] + s1_prod_ff[1] + s1_prod_ff[2] + s1_prod_ff[3];
      s2_pm_sat = (|s1_pm_ff[23:17]) ? 17'h1FFFF : s1_pm_ff[16:0];
      s2_p_prod = 45'({s2_pm_sat, 5'd0}) * 45'(P_RECIP);

      s3_fz_prod  = FZ_PROD_W'(s2_num_ff) * FZ_PROD_W'(FZ_MULT);
      s3_plim     = {1'b0, limits.p_term_limit, 8'd0};
      s3_pmag     = (s2_pq_ff > s3_plim) ? s3_plim : s2_pq_ff;
      s3_pterm_in = s2_err_neg_ff ? 16'(-s3_pmag) : s3_pmag;

      s4_dgain_sum = {1'b0, s3_dbase_ff, 8'd0} + 21'(s3_fz_ff);
      s4_dgain_in  = s4_dgain_sum[20] ? DGAIN_MAX : s4_dgain_sum[19:0];

      s6_md_sat = (|s5_md_ff[35:26]) ? 26'h3FFFFFF : s5_md_ff[25:0];
      s6_d_prod = 47'(s6_md_sat[25:3]) * 47'(D_RECIP);

      out_dterm   = s6_rate_neg_ff ? $signed({1'b0, s6_dq_ff}) : -$signed({1'b0, s6_dq_ff});
      out_sum     = out_dterm + 18'(s6_pterm_ff);
      out_lim     = $signed({3'd0, limits.drive_limit, 8'd0});
      priority if (out_sum > out_lim) begin
         out_clamped = out_lim;
      end else if (out_sum < -out_lim) begin
         out_clamped = -out_lim;
      end else begin
         out_clamped = out_sum;
      end
      rsp_data_in.drive       = 16'(out_clamped);
      rsp_data_in.d_gain_used = s6_dgain_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         s3_valid_ff   <= 1'b0;
         s4_valid_ff   <= 1'b0;
         s5_valid_ff   <= 1'b0;
         s6_valid_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         s1_valid_ff   <= head.valid;
         s2_valid_ff   <= s1_valid_ff;
         s3_valid_ff   <= s2_valid_ff;
         s4_valid_ff   <= s3_valid_ff;
         s5_valid_ff   <= s4_valid_ff;
         s6_valid_ff   <= s5_valid_ff;
         rsp_strobe_ff <= s6_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_prod_ff[0]  <= 16'({13'd0, head.item.rule_ll} * {10'd0, head.item.err_w_lo}
                            * {8'd0, head.item.rate_w_lo});
      s1_prod_ff[1]  <= 16'({13'd0, head.item.rule_lh} * {10'd0, head.item.err_w_lo}
                            * {8'd0, head.item.rate_w_hi});
      s1_prod_ff[2]  <= 16'({13'd0, head.item.rule_hl} * {10'd0, head.item.err_w_hi}
                            * {8'd0, head.item.rate_w_lo});
      s1_prod_ff[3]  <= 16'({13'd0, head.item.rule_hh} * {10'd0, head.item.err_w_hi}
                            * {8'd0, head.item.rate_w_hi});
      s1_pm_ff       <= {12'd0, head.item.err_mag} * {12'd0, head.item.p_gain};
      s1_err_neg_ff  <= head.item.err_neg;
      s1_rate_neg_ff <= head.item.rate_neg;
      s1_rate_mag_ff <= head.item.rate_mag;
      s1_dbase_ff    <= head.item.d_gain_base;

      s2_num_ff      <= s2_num_in;
      s2_pq_ff       <= s2_p_prod[44:P_SHIFT];
      s2_err_neg_ff  <= s1_err_neg_ff;
      s2_rate_neg_ff <= s1_rate_neg_ff;
      s2_rate_mag_ff <= s1_rate_mag_ff;
      s2_dbase_ff    <= s1_dbase_ff;

      s3_fz_ff       <= s3_fz_prod[FZ_W+FZ_SHIFT-1:FZ_SHIFT];
      s3_pterm_ff    <= s3_pterm_in;
      s3_rate_neg_ff <= s2_rate_neg_ff;
      s3_rate_mag_ff <= s2_rate_mag_ff;
      s3_dbase_ff    <= s2_dbase_ff;

      s4_dgain_ff    <= s4_dgain_in;
      s4_pterm_ff    <= s3_pterm_ff;
      s4_rate_neg_ff <= s3_rate_neg_ff;
      s4_rate_mag_ff <= s3_rate_mag_ff;

      s5_md_ff       <= {16'd0, s4_dgain_ff} * {20'd0, s4_rate_mag_ff};
      s5_dgain_ff    <= s4_dgain_ff;
      s5_pterm_ff    <= s4_pterm_ff;
      s5_rate_neg_ff <= s4_rate_neg_ff;

      s6_dq_ff       <= s6_d_prod[46:D_SHIFT];
      s6_dgain_ff    <= s5_dgain_ff;
      s6_pterm_ff    <= s5_pterm_ff;
      s6_rate_neg_ff <= s5_rate_neg_ff;

      rsp_data_ff    <= rsp_data_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

FILE: hw/rtl/fuzzy_gain_position_pd.sv
// fuzzy self-tuning pd position controller
// input: drive req_data and raise start; a transfer happens at a rising edge with
//    start high and busy low. busy is high only during reset or with the
//    front queue full, which a continuous stream never reaches
// output: rsp_strobe marks one cycle with rsp_data valid; the receiver must
//    take it then, there is no way to hold results off
// csr: csr_we writes csr_wdata into register csr_index at the edge; limits take
//    the low 7 bits. write only with no item in flight
// path: a transfer passes through a queue slot, six pipeline stages and the output
//    register before the result strobe goes high
// throughput: one item per cycle while busy is low, set by the back-end pipeline
//    that takes a new item from the queue in every cycle that it holds one
// reset: synchronous, clears the queue and all stage valids and loads the
//    register defaults; items in flight are dropped
module fuzzy_gain_position_pd
   import fgp_pkg::*;
#(
   parameter int unsigned FUZZY_SCALE = 2,
   parameter int unsigned QUEUE_DEPTH = 4
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  req_type                req_data,
   output logic                   rsp_strobe,
   output rsp_type                rsp_data,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   gain_set_type   gains_ff;
   limit_set_type  limits_ff;
   logic           queue_full;
   logic           push;
   item_type       push_item;
   queue_head_type head;

   // configuration registers, upper data bits of the limits are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         gains_ff.p_gain_low      <= RST_P_GAIN_LOW;
         gains_ff.p_gain_high     <= RST_P_GAIN_HIGH;
         gains_ff.d_gain_base     <= RST_D_GAIN_BASE;
         gains_ff.p_gain_low_alt  <= RST_P_GAIN_LOW_ALT;
         gains_ff.p_gain_high_alt <= RST_P_GAIN_HIGH_ALT;
         gains_ff.d_gain_base_alt <= RST_D_GAIN_BASE_ALT;
         limits_ff.p_term_limit   <= RST_P_TERM_LIMIT;
         limits_ff.drive_limit    <= RST_DRIVE_LIMIT;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_P_GAIN_LOW:      gains_ff.p_gain_low      <= csr_wdata;
            REG_P_GAIN_HIGH:     gains_ff.p_gain_high     <= csr_wdata;
            REG_D_GAIN_BASE:     gains_ff.d_gain_base     <= csr_wdata;
            REG_P_GAIN_LOW_ALT:  gains_ff.p_gain_low_alt  <= csr_wdata;
            REG_P_GAIN_HIGH_ALT: gains_ff.p_gain_high_alt <= csr_wdata;
            REG_D_GAIN_BASE_ALT: gains_ff.d_gain_base_alt <= csr_wdata;
            REG_P_TERM_LIMIT:    limits_ff.p_term_limit   <= csr_wdata[LIMIT_W-1:0];
            REG_DRIVE_LIMIT:     limits_ff.drive_limit    <= csr_wdata[LIMIT_W-1:0];
         endcase
      end
   end

   // front: handshake, error, gain pick, memberships and rule lookups
   fgp_front u_front (
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .gains      (gains_ff),
      .queue_full (queue_full),
      .push       (push),
      .item       (push_item)
   );

   // short queue of classified items between front and back
   fgp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (queue_full),
      .head      (head)
   );

   // back: fuzzy d gain, p and d terms, output clamp
   fgp_back #(
      .FUZZY_SCALE (FUZZY_SCALE)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .limits     (limits_ff),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   // every transfer is followed by a result strobe
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##8 rsp_strobe)
      else $error("result strobe missing after input transfer");

   // the back end drains one item per cycle, so the queue never backs up
   a_no_backlog: assert property (@(posedge clock) disable iff (reset)
      !queue_full)
      else $error("front queue filled up");

   // output always inside the configured drive limit
   a_drive_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |->
         ($signed(rsp_data.drive) <= $signed({1'b0, limits_ff.drive_limit, 8'd0})) &&
         ($signed(rsp_data.drive) >= -$signed({1'b0, limits_ff.drive_limit, 8'd0})))
      else $error("drive outside limit");

endmodule

FILE: tb/fuzzy_gain_position_pd_test.sv
`timescale 1ns / 100ps

module fuzzy_gain_position_pd_test;
   import fgp_pkg::*;

   localparam int     FUZZY_GAIN_SCALE = 2;      // matches the block's default
   localparam int     PHASE_COUNT      = 8;
   localparam int     ITEMS_PER_PHASE  = 175;    // random part, about 1400 in all
   localparam int     MAX_REPORTS      = 10;
   localparam int     DRAIN_CYCLES     = 16;     // extra settle time once every result is back
   localparam longint CYCLE_LIMIT      = 200000;

   // register settings used between phases
   localparam int SET_ALL_ONES    = 0;
   localparam int SET_ALL_ZERO    = 1;
   localparam int SET_SMALL_GAINS = 2;
   localparam int SET_RANDOM      = 3;

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   req_type                req_data;
   logic                   rsp_strobe;
   rsp_type                rsp_data;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   // commands waiting to be sent and drive values waiting to come back
   req_type pending_cmds[$];
   rsp_type expected_drives[$];
   rsp_type oldest_drive;

   bit     took_cmd;
   int     idle_pct;
   int     mismatch_count;
   longint cycle_count;

   // shadow copy of the gain and limit registers
   logic [GAIN_W-1:0]  kp_low, kp_high, kd_base;
   logic [GAIN_W-1:0]  kp_low_alt, kp_high_alt, kd_base_alt;
   logic [LIMIT_W-1:0] p_clamp, drive_clamp;

   fuzzy_gain_position_pd u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // rule table row for one error level, column 0 in the top bits
   function automatic int rule_at(input int row, input int col);
      logic [20:0] bits;
      case (row)
         0: bits = {3'd4, 3'd3, 3'd1, 3'd0, 3'd0, 3'd0, 3'd0};
         1: bits = {3'd4, 3'd4, 3'd2, 3'd0, 3'd0, 3'd0, 3'd0};
         2: bits = {3'd4, 3'd4, 3'd2, 3'd0, 3'd0, 3'd0, 3'd0};
         3: bits = {3'd4, 3'd4, 3'd3, 3'd0, 3'd3, 3'd4, 3'd4};
         4: bits = {3'd0, 3'd0, 3'd0, 3'd0, 3'd2, 3'd4, 3'd4};
         5: bits = {3'd0, 3'd0, 3'd0, 3'd0, 3'd2, 3'd4, 3'd4};
         default: bits = {3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd3, 3'd4};
      endcase
      return int'(bits[20-3*col -: 3]);
   endfunction

   // triangular membership, levels given as table indices 0..6
   function automatic void fuzzify(input longint x, input bit is_rate,
                                   output int lvl_lo, output int lvl_hi,
                                   output longint w_lo, output longint w_hi,
                                   output longint den);
      longint mag, k0, k1, k2, k3, lo_knee, hi_knee;
      int     band;
      mag = (x < 0) ? -x : x;
      k0  = is_rate ? 110 : 0;
      k1  = is_rate ? 150 : 50;
      k2  = is_rate ? 250 : 100;
      k3  = is_rate ? 350 : 150;
      // centre and saturated regions split evenly between one level
      lvl_lo = 3;
      lvl_hi = 3;
      w_lo   = 1;
      w_hi   = 1;
      den    = 2;
      if (mag > k3) begin
         lvl_lo = (x < 0) ? 0 : 6;
         lvl_hi = lvl_lo;
      end else if (mag > k0) begin
         band    = (mag > k2) ? 2 : ((mag > k1) ? 1 : 0);
         lo_knee = (band == 0) ? k0 : ((band == 1) ? k1 : k2);
         hi_knee = (band == 0) ? k1 : ((band == 1) ? k2 : k3);
         den     = hi_knee - lo_knee;
         if (x > 0) begin
            lvl_lo = 3 + band;
            lvl_hi = 4 + band;
            w_lo   = hi_knee - mag;
            w_hi   = mag - lo_knee;
         end else begin
            lvl_lo = 2 - band;
            lvl_hi = 3 - band;
            w_lo   = mag - lo_knee;
            w_hi   = hi_knee - mag;
         end
      end
   endfunction

   // expected drive and effective d gain for one command
   function automatic rsp_type predict_drive(input req_type cmd);
      longint  err, yaw, pgain, dbase, num, den, fz, dgain;
      longint  pterm, dterm, total, plim, dlim;
      longint  we_lo, we_hi, wr_lo, wr_hi, den_e, den_r;
      int      e_lo, e_hi, r_lo, r_hi;
      rsp_type res;
      err = longint'($signed(cmd.target_pos)) - longint'($signed(cmd.measured_pos));
      yaw = longint'($signed(cmd.yaw_rate));
      if (cmd.alt_mode) begin
         pgain = longint'(cmd.high_track ? kp_high_alt : kp_low_alt);
         dbase = longint'(kd_base_alt);
      end else begin
         pgain = longint'(cmd.high_track ? kp_high : kp_low);
         dbase = longint'(kd_base);
      end

      // bilinear blend of the four rule cells, truncated into q.8
      fuzzify(err, 1'b0, e_lo, e_hi, we_lo, we_hi, den_e);
      fuzzify(yaw, 1'b1, r_lo, r_hi, wr_lo, wr_hi, den_r);
      num = rule_at(e_lo, r_lo) * we_lo * wr_lo + rule_at(e_lo, r_hi) * we_lo * wr_hi
          + rule_at(e_hi, r_lo) * we_hi * wr_lo + rule_at(e_hi, r_hi) * we_hi * wr_hi;
      den = den_e * den_r;
      fz  = (num * FUZZY_GAIN_SCALE * 256) / den;

      dgain = dbase * 256 + fz;
      if (dgain > 1048575) dgain = 1048575;

      plim  = longint'(p_clamp) * 256;
      pterm = (err * pgain * 256) / 1000;
      if (pterm > plim)  pterm = plim;
      if (pterm < -plim) pterm = -plim;

      dterm = (dgain * (-yaw)) / 1000;

      dlim  = longint'(drive_clamp) * 256;
      total = pterm + dterm;
      if (total > dlim)  total = dlim;
      if (total < -dlim) total = -dlim;

      res.drive       = total[15:0];
      res.d_gain_used = dgain[19:0];
      return res;
   endfunction

   // sampling side: register shadow, result check, prediction on each transfer
   always @(posedge clock) begin
      took_cmd <= !reset && start && !busy;
      if (reset) begin
         kp_low      <= 12'd230;
         kp_high     <= 12'd320;
         kd_base     <= 12'd14;
         kp_low_alt  <= 12'd155;
         kp_high_alt <= 12'd155;
         kd_base_alt <= 12'd0;
         p_clamp     <= 7'd100;
         drive_clamp <= 7'd100;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_P_GAIN_LOW:      kp_low      <= csr_wdata[GAIN_W-1:0];
               REG_P_GAIN_HIGH:     kp_high     <= csr_wdata[GAIN_W-1:0];
               REG_D_GAIN_BASE:     kd_base     <= csr_wdata[GAIN_W-1:0];
               REG_P_GAIN_LOW_ALT:  kp_low_alt  <= csr_wdata[GAIN_W-1:0];
               REG_P_GAIN_HIGH_ALT: kp_high_alt <= csr_wdata[GAIN_W-1:0];
               REG_D_GAIN_BASE_ALT: kd_base_alt <= csr_wdata[GAIN_W-1:0];
               REG_P_TERM_LIMIT:    p_clamp     <= csr_wdata[LIMIT_W-1:0];
               REG_DRIVE_LIMIT:     drive_clamp <= csr_wdata[LIMIT_W-1:0];
               default: ;
            endcase
         end

         // check before pushing so a result with nothing pending is caught
         if (rsp_strobe) begin
            if (expected_drives.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("cycle %0d: result with nothing expected, drive %0d d_gain_used %0d",
                           cycle_count, $signed(rsp_data.drive), rsp_data.d_gain_used);
            end else begin
               oldest_drive = expected_drives.pop_front();
               if (rsp_data.drive !== oldest_drive.drive) begin
                  mismatch_count++;
                  if (mismatch_count <= MAX_REPORTS)
                     $display("cycle %0d: drive expected %0d got %0d", cycle_count,
                              $signed(oldest_drive.drive), $signed(rsp_data.drive));
               end
               if (rsp_data.d_gain_used !== oldest_drive.d_gain_used) begin
                  mismatch_count++;
                  if (mismatch_count <= MAX_REPORTS)
                     $display("cycle %0d: d_gain_used expected %0d got %0d", cycle_count,
                              oldest_drive.d_gain_used, rsp_data.d_gain_used);
               end
            end
         end

         // registers are stable while commands are in flight
         if (start && !busy)
            expected_drives.push_back(predict_drive(req_data));
      end
   end

   // driver: retire the command taken at the last edge, then present the next
   always @(negedge clock) begin
      if (took_cmd)
         void'(pending_cmds.pop_front());
      if (reset || pending_cmds.size() == 0) begin
         start <= 1'b0;
      end else if (start && !took_cmd) begin
         // held off by busy, keep the same command up
         start    <= 1'b1;
         req_data <= pending_cmds[0];
      end else if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
      end else begin
         start    <= 1'b1;
         req_data <= pending_cmds[0];
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic add_cmd(input int tgt, input int meas, input int rate,
                          input bit alt, input bit high);
      req_type cmd;
      cmd.target_pos   = tgt[11:0];
      cmd.measured_pos = meas[11:0];
      cmd.yaw_rate     = rate[15:0];
      cmd.alt_mode     = alt;
      cmd.high_track   = high;
      pending_cmds.push_back(cmd);
   endtask

   // mostly errors and rates inside the membership bands, some full range
   task automatic add_random_cmd();
      int err, meas, tgt, rate;
      if ($urandom_range(99) < 65) begin
         err  = int'($urandom_range(400)) - 200;
         meas = int'($urandom_range(3695)) - 1848;
         tgt  = meas + err;
      end else begin
         meas = $urandom;
         tgt  = $urandom;
      end
      case ($urandom_range(2))
         0: rate = int'($urandom_range(900)) - 450;
         1: begin
            // rate on or next to a knee, either sign
            case ($urandom_range(3))
               0: rate = 110;
               1: rate = 150;
               2: rate = 250;
               default: rate = 350;
            endcase
            rate = rate + int'($urandom_range(2)) - 1;
            if ($urandom_range(1)) rate = -rate;
         end
         default: rate = $urandom;
      endcase
      add_cmd(tgt, meas, rate, 1'($urandom_range(1)), 1'($urandom_range(1)));
   endtask

   // call at a falling edge; leaves csr_we high for the caller to drop
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
   endtask

   task automatic program_regs(input int setting);
      logic [CSR_DATA_W-1:0] val [8];
      for (int i = 0; i < 8; i++) begin
         case (setting)
            SET_ALL_ONES:    val[i] = '1;
            SET_ALL_ZERO:    val[i] = '0;
            // moderate gains with open limits, so the clamps rarely bite
            SET_SMALL_GAINS: val[i] = (i < 6) ? CSR_DATA_W'($urandom_range(400)) : '1;
            default:         val[i] = CSR_DATA_W'($urandom);
         endcase
      end
      write_reg(REG_P_GAIN_LOW,      val[0]);
      write_reg(REG_P_GAIN_HIGH,     val[1]);
      write_reg(REG_D_GAIN_BASE,     val[2]);
      write_reg(REG_P_GAIN_LOW_ALT,  val[3]);
      write_reg(REG_P_GAIN_HIGH_ALT, val[4]);
      write_reg(REG_D_GAIN_BASE_ALT, val[5]);
      write_reg(REG_P_TERM_LIMIT,    val[6]);
      write_reg(REG_DRIVE_LIMIT,     val[7]);
      csr_we <= 1'b0;
   endtask

   // wait for every command and result, then let the pipeline settle
   task automatic wait_idle();
      while (pending_cmds.size() != 0 || expected_drives.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   initial begin
      int phase_idle [PHASE_COUNT];
      int phase_setting [PHASE_COUNT];
      phase_idle    = '{82, 24, 0, 82, 24, 0, 82, 24};
      phase_setting = '{SET_ALL_ONES, SET_ALL_ZERO, SET_SMALL_GAINS, SET_RANDOM,
                        SET_SMALL_GAINS, SET_RANDOM, SET_RANDOM, SET_SMALL_GAINS};
      reset          = 1'b1;
      start          = 1'b0;
      req_data       = '0;
      csr_we         = 1'b0;
      csr_index      = '0;
      csr_wdata      = '0;
      idle_pct       = 0;
      mismatch_count = 0;
      cycle_count    = 0;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed commands on the reset registers, back to back
      add_cmd(2047, -2048, 0, 0, 0);          // largest positive error
      add_cmd(-2048, 2047, 0, 0, 1);          // largest negative error
      add_cmd(0, 0, 0, 1, 0);                 // zero error, zero rate
      add_cmd(0, 0, 32767, 1, 1);             // largest rate
      add_cmd(0, 0, -32768, 0, 0);            // most negative rate
      add_cmd(50, 0, 110, 0, 1);              // error on first knee, rate on inner knee
      add_cmd(-50, 0, -111, 1, 0);
      add_cmd(100, 0, 150, 1, 1);             // both on a middle knee
      add_cmd(0, 100, -150, 0, 0);
      add_cmd(150, 0, 250, 0, 1);             // error on outer knee
      add_cmd(-150, 0, -250, 1, 0);
      add_cmd(151, 0, 350, 1, 1);             // just past the outer error knee
      add_cmd(0, 151, -351, 0, 0);            // both past the outer knees
      add_cmd(1, 0, 351, 0, 1);
      add_cmd(0, 1, -1, 1, 0);                // smallest nonzero error, rate in dead zone
      add_cmd(75, 0, 200, 1, 1);              // mid band weights
      add_cmd(-125, 0, -300, 0, 0);
      add_cmd(25, 0, 130, 0, 1);
      add_cmd(2047, 2047, -32768, 1, 1);
      add_cmd(-2048, -2048, 32767, 0, 0);
      add_cmd(-1, -2048, -1, 0, 1);
      add_cmd(-2048, -1, 1000, 1, 0);
      wait_idle();

      // random phases, each with its own register setting and sender pacing
      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         program_regs(phase_setting[ph]);
         idle_pct = phase_idle[ph];
         for (int n = 0; n < ITEMS_PER_PHASE; n++)
            add_random_cmd();
         wait_idle();
      end

      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

FILE: files.f
hw/rtl/fgp_pkg.sv
hw/rtl/fgp_front.sv
hw/rtl/fgp_queue.sv
hw/rtl/fgp_back.sv
hw/rtl/fuzzy_gain_position_pd.sv
tb/fuzzy_gain_position_pd_test.sv
